[rtl/hbs_pkg.sv]
// Shared types, codes and widths for the heartbeat supervisor.
`timescale 1ns / 1ps
`default_nettype none

package hbs_pkg;

    localparam int TIME_BITS  = 48;
    localparam int COUNT_BITS = 8;
    localparam int CFG_BITS   = 32;
    localparam int LIMIT_BITS = 8;
    localparam int CMD_BITS   = 3;
    localparam int VAL_BITS   = 8;
    localparam int ACT_BITS   = 2;
    localparam int CFG_IDX_BITS = 2;

    localparam int IN_TDATA_W  = ((VAL_BITS + TIME_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_W = ACT_BITS + 1 + COUNT_BITS;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_MAIN    = 3'd0,
        CMD_SECOND  = 3'd1,
        CMD_CONTROL = 3'd2,
        CMD_EXIT    = 3'd3,
        CMD_TICK    = 3'd4,
        CMD_LIMIT   = 3'd5
    } t_cmd;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_IDLE         = 2'd0,
        ACT_SHUTDOWN     = 2'd1,
        ACT_RESTART_EXIT = 2'd2,
        ACT_GRACE        = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_PERIOD  = 2'd1,
        CFG_LIMIT   = 2'd2
    } t_cfg_idx;

    // Main heartbeat payloads
    localparam logic [VAL_BITS-1:0] HB_SYNC   = 8'd1;
    localparam logic [VAL_BITS-1:0] HB_PAUSE  = 8'd2;
    localparam logic [VAL_BITS-1:0] HB_RESUME = 8'd3;

    // Control payloads
    localparam logic [VAL_BITS-1:0] CTL_POWER_OFF  = 8'd0;
    localparam logic [VAL_BITS-1:0] CTL_UPDATE_ON  = 8'd1;
    localparam logic [VAL_BITS-1:0] CTL_UPDATE_OFF = 8'd2;
    localparam logic [VAL_BITS-1:0] CTL_KILL_ON    = 8'd5;
    localparam logic [VAL_BITS-1:0] CTL_KILL_OFF   = 8'd6;

    localparam logic [CFG_BITS-1:0]   RST_TIMEOUT = 32'd5000;
    localparam logic [CFG_BITS-1:0]   RST_PERIOD  = 32'd3600000;
    localparam logic [LIMIT_BITS-1:0] RST_LIMIT   = 8'd11;

    typedef struct packed {
        logic [CFG_BITS-1:0]   timeout_ms;
        logic [CFG_BITS-1:0]   period_ms;
        logic [LIMIT_BITS-1:0] count_limit;
    } t_cfg;

    typedef struct packed {
        logic [COUNT_BITS-1:0] fail_count;
        logic                  monitoring_enabled;
        t_action               action;
    } t_result;

endpackage

`default_nettype wire

[rtl/hbs_cfg_regs.sv]
// Configuration register bank of the heartbeat supervisor.
`timescale 1ns / 1ps
`default_nettype none

module hbs_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [hbs_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [hbs_pkg::CFG_BITS-1:0]     i_cfg_data,
    output hbs_pkg::t_cfg                         o_cfg
);
    import hbs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms  <= RST_TIMEOUT;
            r_cfg.period_ms   <= RST_PERIOD;
            r_cfg.count_limit <= RST_LIMIT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TIMEOUT: r_cfg.timeout_ms  <= i_cfg_data;
                CFG_PERIOD:  r_cfg.period_ms   <= i_cfg_data;
                CFG_LIMIT:   r_cfg.count_limit <= i_cfg_data[LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/hbs_core.sv]
// Supervisor state and per-event update logic.
`timescale 1ns / 1ps
`default_nettype none

module hbs_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire logic [hbs_pkg::CMD_BITS-1:0]  i_cmd,
    input  wire logic [hbs_pkg::VAL_BITS-1:0]  i_value,
    input  wire logic [hbs_pkg::TIME_BITS-1:0] i_now,
    input  wire hbs_pkg::t_cfg                 i_cfg,
    output hbs_pkg::t_result                   o_result
);
    import hbs_pkg::*;

    logic [TIME_BITS-1:0]  r_last_hb, n_last_hb;
    logic [TIME_BITS-1:0]  r_fail_reset, n_fail_reset;
    logic [COUNT_BITS-1:0] r_fail_count, n_fail_count;
    logic r_sync, n_sync;
    logic r_paused, n_paused;
    logic r_power_off, n_power_off;
    logic r_update, n_update;
    logic r_kill, n_kill;
    logic r_exited, n_exited;

    logic [TIME_BITS-1:0] hb_elapsed;
    logic [TIME_BITS-1:0] fr_elapsed;
    logic                 hb_timeout;
    logic                 fr_expired;
    t_action              action;

    // Modular differences; widths wrap exactly like the time base.
    assign hb_elapsed = i_now - r_last_hb;
    assign fr_elapsed = i_now - r_fail_reset;
    assign hb_timeout = hb_elapsed > TIME_BITS'(i_cfg.timeout_ms);
    assign fr_expired = fr_elapsed > TIME_BITS'(i_cfg.period_ms);

    always_comb begin
        n_last_hb    = r_last_hb;
        n_fail_reset = r_fail_reset;
        n_fail_count = r_fail_count;
        n_sync       = r_sync;
        n_paused     = r_paused;
        n_power_off  = r_power_off;
        n_update     = r_update;
        n_kill       = r_kill;
        n_exited     = r_exited;
        action       = ACT_IDLE;

        unique case (t_cmd'(i_cmd))
            CMD_MAIN: begin
                if (i_value == HB_PAUSE) begin
                    n_paused = 1'b1;
                end else if (i_value == HB_RESUME) begin
                    n_paused = 1'b0;
                end
                // A main beat clears any pending sync request.
                n_sync    = 1'b0;
                n_last_hb = i_now;
            end
            CMD_SECOND: ;
            CMD_CONTROL: begin
                unique case (i_value)
                    CTL_POWER_OFF:  n_power_off = 1'b1;
                    CTL_UPDATE_ON:  n_update    = 1'b1;
                    CTL_UPDATE_OFF: n_update    = 1'b0;
                    CTL_KILL_ON:    n_kill      = 1'b1;
                    CTL_KILL_OFF:   n_kill      = 1'b0;
                    default: ;
                endcase
            end
            CMD_EXIT: n_exited = 1'b1;
            CMD_TICK: begin
                if (r_power_off) begin
                    action = ACT_SHUTDOWN;
                end else if (r_paused || r_update) begin
                    action = ACT_IDLE;
                end else if (r_exited) begin
                    action = ACT_RESTART_EXIT;
                end else if (r_kill) begin
                    if (hb_timeout) begin
                        if (r_fail_count != COUNT_MAX) begin
                            n_fail_count = r_fail_count + 1'b1;
                        end
                        n_last_hb = i_now;
                        action    = ACT_GRACE;
                    end
                    if (fr_expired) begin
                        n_fail_reset = i_now;
                        n_fail_count = '0;
                    end
                end
            end
            CMD_LIMIT: begin
                if (r_kill && (r_fail_count > COUNT_BITS'(i_cfg.count_limit))) begin
                    n_kill = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_hb    <= '0;
            r_fail_reset <= '0;
            r_fail_count <= '0;
            r_sync       <= 1'b0;
            r_paused     <= 1'b0;
            r_power_off  <= 1'b0;
            r_update     <= 1'b0;
            r_kill       <= 1'b1;
            r_exited     <= 1'b0;
        end else if (i_fire) begin
            r_last_hb    <= n_last_hb;
            r_fail_reset <= n_fail_reset;
            r_fail_count <= n_fail_count;
            r_sync       <= n_sync;
            r_paused     <= n_paused;
            r_power_off  <= n_power_off;
            r_update     <= n_update;
            r_kill       <= n_kill;
            r_exited     <= n_exited;
        end
    end

    assign o_result.action             = action;
    assign o_result.monitoring_enabled = n_kill;
    assign o_result.fail_count         = n_fail_count;

    // Power off and exit requests are sticky until reset.
    a_power_off_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_power_off |=> r_power_off)
        else $error("power off request dropped");

    a_exit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exited |=> r_exited)
        else $error("exit flag dropped");

    // Only a tick may change the failure count.
    a_count_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_cmd != CMD_TICK)) |=> $stable(r_fail_count))
        else $error("failure count changed outside a tick");

    // Monitoring comes back on only through a kill-enable control beat.
    a_kill_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_kill)) |->
            $past(i_fire && (i_cmd == CMD_CONTROL) && (i_value == CTL_KILL_ON)))
        else $error("monitoring enabled without control beat");

    // A sync request never survives its beat.
    a_sync_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sync)
        else $error("sync request left pending");

endmodule

`default_nettype wire

[rtl/heartbeat_supervisor_top.sv]
// Top level of the heartbeat supervisor: stream ports, input and result registers.
`timescale 1ns / 1ps
`default_nettype none

// Heartbeat supervisor. Every event beat on the slave stream (command in tuser, payload and
// millisecond timestamp in tdata) yields exactly one result beat on the master stream:
// the tick action, the current monitoring-enable flag and the failure count after the
// event. The block takes one beat per clock while the result stream accepts beats;
// back-pressure there stalls the event stream. A beat passes through the input register
// and then the result register. The supervisor state updates at the edge that loads the
// result register, so each event sees the state left by the one before it with no
// bubble. Configuration registers (timeout, failure-clear period, failure limit) are
// written through the plain write port and should be changed only while no event is in
// flight. Timestamps are compared by modular difference, so the time base may wrap freely.
module heartbeat_supervisor_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Event stream
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // [7:0] value, [55:8] now_ms
    input  wire logic [hbs_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // [2:0] command
    input  wire logic [hbs_pkg::CMD_BITS-1:0]        i_s_tuser,
    // Result stream
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // [1:0] action, [2] monitoring_enabled, [10:3] fail_count, rest zero
    output logic [hbs_pkg::OUT_TDATA_W-1:0]          o_m_tdata,
    // Configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [hbs_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [hbs_pkg::CFG_BITS-1:0]        i_cfg_data
);
    import hbs_pkg::*;

    t_cfg    cfg;
    t_result result;

    // Input register
    logic                  r_in_valid;
    logic [CMD_BITS-1:0]   r_in_cmd;
    logic [VAL_BITS-1:0]   r_in_value;
    logic [TIME_BITS-1:0]  r_in_now;

    // Result register
    logic                  r_out_valid;
    t_result               r_out;

    logic out_ready;
    logic fire;

    // The result register frees up when it is empty or its beat leaves this cycle.
    assign out_ready  = !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && out_ready;
    assign o_s_tready = !r_in_valid || out_ready;

    hbs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hbs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cmd    (r_in_cmd),
        .i_value  (r_in_value),
        .i_now    (r_in_now),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Capture a new event whenever the input register is free or drains this cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_cmd   <= i_s_tuser;
            r_in_value <= i_s_tdata[VAL_BITS-1:0];
            r_in_now   <= i_s_tdata[VAL_BITS +: TIME_BITS];
        end
    end

    // Hold the result until the consumer takes it; advance on every processed event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_out.fail_count, r_out.monitoring_enabled,
                                      r_out.action});

    // A held result beat must not change while the consumer stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result beat changed while stalled");

    // Every processed event lands in the result register.
    a_fire_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed event lost");

    // With the result side free, the input side never stalls.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || i_m_tready) |-> o_s_tready)
        else $error("input stalled with free result register");

endmodule

`default_nettype wire
